/* design/ppsc_pkg.sv */
// ppsc_pkg: shared constants and controller/datapath command and status
// types for the prime pair sum counter; no dependencies
`timescale 1ns / 1ps

package ppsc_pkg;

    localparam int LIMIT     = 131072;
    localparam int ADDR_W    = $clog2(LIMIT);
    localparam int NW        = 17;
    localparam int WIN_W     = 11;
    localparam int WIN_MAX   = 1024;
    localparam int WIN_RESET = 100;
    localparam int MIN_M     = 4;
    localparam int M_STEP    = 2;
    localparam int PC_W      = 17;
    localparam int SUM_W     = 27;
    localparam int SQ_W      = 43;
    localparam int CNT_W     = 11;
    // width of a scanned number, and of a signed window number
    localparam int CW        = (NW > ADDR_W) ? NW : ADDR_W;
    localparam int MW        = CW + 2;
    // sieve index width, enough for sqrt(LIMIT) + 1
    localparam int IW        = (ADDR_W + 1) / 2 + 1;

    typedef struct packed {
        logic clr_step;
        logic sieve_init;
        logic sieve_rd;
        logic mark_init;
        logic mark_step;
        logic sieve_next;
        logic item_load;
        logic pair_init;
        logic scan;
        logic square;
        logic accum;
        logic win_next;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic sieve_more;
        logic map_prime;
        logic mark_last;
        logic skip_m;
        logic scan_done;
        logic last_m;
        logic out_free;
    } status_t;

endpackage

/* design/ppsc_ram.sv */
// ppsc_ram: generic memory, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps

module ppsc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* design/ppsc_datapath.sv */
// ppsc_datapath: sieve counters, composite map, pair scan, window sums and
// output register; depends on ppsc_pkg and ppsc_ram
`timescale 1ns / 1ps

module ppsc_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ppsc_pkg::cmd_t           cmd,
    output ppsc_pkg::status_t        status,
    input  logic                     cfg_valid,
    input  logic [ppsc_pkg::WIN_W-1:0] cfg_data,
    input  logic [ppsc_pkg::NW-1:0]  n,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ppsc_pkg::PC_W-1:0]  pair_count,
    output logic [ppsc_pkg::SUM_W-1:0] window_sum,
    output logic [ppsc_pkg::SQ_W-1:0]  window_sum_sq,
    output logic [ppsc_pkg::CNT_W-1:0] window_count
);

    import ppsc_pkg::*;

    localparam logic [ADDR_W:0]       LIMIT_J  = (ADDR_W + 1)'(LIMIT);
    localparam logic [CW:0]           LIMIT_C  = (CW + 1)'(LIMIT);
    localparam logic signed [MW-1:0]  MIN_M_S  = MW'(MIN_M);
    localparam logic signed [MW-1:0]  LAST_M_S = MW'(LIMIT - 1);
    localparam logic [WIN_W-1:0]      WIN_MAX_C = WIN_W'(WIN_MAX);

    // configuration
    logic [WIN_W-1:0] window_half_reg;

    // sieve
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [IW-1:0]     i_reg;
    logic [ADDR_W:0]   sq_reg;
    logic [ADDR_W:0]   j_reg;
    logic [ADDR_W:0]   i_ext;
    logic [ADDR_W:0]   j_plus_i;

    // memory ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic              ram_rdata_a;
    logic              ram_rdata_b;

    // item and window
    logic [NW-1:0]          n_reg;
    logic signed [MW-1:0]   m_reg;
    logic signed [MW-1:0]   m_end_reg;
    logic                   phase_n_reg;
    logic [WIN_W-1:0]       w_clamp;
    logic signed [MW-1:0]   n_s;
    logic signed [MW-1:0]   w_s;

    // pair scan
    logic [CW-1:0]     cur_reg;
    logic [CW-1:0]     p_reg;
    logic [PC_W-1:0]   r_reg;
    logic              pend_reg;
    logic              aok_reg;
    logic              bok_reg;
    logic [CW-1:0]     half;
    logic [CW-1:0]     q;
    logic              issue;
    logic              a_ok;
    logic              b_ok;
    logic              hit;

    // accumulation and output
    logic [2*PC_W-1:0] sqr_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SQ_W-1:0]   sumsq_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              out_valid_reg;
    logic [PC_W-1:0]   pair_count_reg;
    logic [SUM_W-1:0]  window_sum_reg;
    logic [SQ_W-1:0]   window_sum_sq_reg;
    logic [CNT_W-1:0]  window_count_reg;

    ppsc_ram #(
        .WIDTH (1),
        .DEPTH (LIMIT)
    ) u_map (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    assign i_ext    = (ADDR_W + 1)'(i_reg);
    assign j_plus_i = j_reg + i_ext;

    assign ram_we      = cmd.clr_step | cmd.mark_step;
    assign ram_waddr   = cmd.clr_step ? clr_cnt_reg : j_reg[ADDR_W-1:0];
    // 0 and 1 are marked non-prime during the clearing pass
    assign ram_wdata   = cmd.clr_step ? (clr_cnt_reg < ADDR_W'(2)) : 1'b1;
    assign ram_raddr_a = cmd.sieve_rd ? ADDR_W'(i_reg) : p_reg[ADDR_W-1:0];
    assign ram_raddr_b = q[ADDR_W-1:0];

    assign w_clamp = (window_half_reg > WIN_MAX_C) ? WIN_MAX_C : window_half_reg;
    assign n_s     = $signed(MW'(n));
    assign w_s     = $signed(MW'(w_clamp));

    assign half  = cur_reg >> 1;
    assign q     = cur_reg - p_reg;
    assign issue = cmd.scan && (p_reg <= half);
    assign a_ok  = {1'b0, p_reg} < LIMIT_C;
    assign b_ok  = {1'b0, q} < LIMIT_C;
    assign hit   = pend_reg & aok_reg & bok_reg & ~ram_rdata_a & ~ram_rdata_b;

    assign status.clr_last   = (clr_cnt_reg == ADDR_W'(LIMIT - 1));
    assign status.sieve_more = (sq_reg < LIMIT_J);
    assign status.map_prime  = ~ram_rdata_a;
    assign status.mark_last  = (j_plus_i >= LIMIT_J);
    assign status.skip_m     = !phase_n_reg && ((m_reg < MIN_M_S) || (m_reg > LAST_M_S));
    assign status.scan_done  = !issue && !pend_reg;
    assign status.last_m     = !phase_n_reg && (m_reg >= m_end_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_half_reg <= WIN_W'(WIN_RESET);
            clr_cnt_reg     <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_n_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                window_half_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            pend_reg <= issue;
            if (cmd.item_load)
            begin
                phase_n_reg <= 1'b1;
            end
            else if (cmd.win_next && phase_n_reg)
            begin
                phase_n_reg <= 1'b0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.sieve_init)
        begin
            i_reg  <= IW'(2);
            sq_reg <= (ADDR_W + 1)'(4);
        end
        else if (cmd.sieve_next)
        begin
            i_reg  <= i_reg + IW'(1);
            sq_reg <= sq_reg + (i_ext << 1) + (ADDR_W + 1)'(1);
        end
        if (cmd.mark_init)
        begin
            j_reg <= sq_reg;
        end
        else if (cmd.mark_step)
        begin
            j_reg <= j_plus_i;
        end

        if (cmd.item_load)
        begin
            n_reg     <= n;
            m_reg     <= n_s - w_s;
            m_end_reg <= n_s + w_s;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (cmd.win_next && !phase_n_reg)
        begin
            m_reg <= m_reg + MW'(M_STEP);
        end

        if (cmd.pair_init)
        begin
            cur_reg <= phase_n_reg ? CW'(n_reg) : m_reg[CW-1:0];
            p_reg   <= CW'(2);
            r_reg   <= '0;
        end
        else
        begin
            if (issue)
            begin
                p_reg <= p_reg + CW'(1);
            end
            if (hit)
            begin
                r_reg <= r_reg + PC_W'(1);
            end
        end
        aok_reg <= a_ok;
        bok_reg <= b_ok;

        if (cmd.square)
        begin
            sqr_reg <= r_reg * r_reg;
        end
        if (cmd.accum)
        begin
            if (phase_n_reg)
            begin
                pc_reg <= r_reg;
            end
            else
            begin
                sum_reg   <= sum_reg + SUM_W'(r_reg);
                sumsq_reg <= sumsq_reg + SQ_W'(sqr_reg);
                cnt_reg   <= cnt_reg + CNT_W'(1);
            end
        end

        if (cmd.out_load)
        begin
            pair_count_reg    <= pc_reg;
            window_sum_reg    <= sum_reg;
            window_sum_sq_reg <= sumsq_reg;
            window_count_reg  <= cnt_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pair_count    = pair_count_reg;
    assign window_sum    = window_sum_reg;
    assign window_sum_sq = window_sum_sq_reg;
    assign window_count  = window_count_reg;

endmodule

/* design/ppsc_ctrl.sv */
// ppsc_ctrl: controller state machine for sieve fill and per-request scan
// depends on ppsc_pkg
`timescale 1ns / 1ps

module ppsc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  ppsc_pkg::status_t   status,
    output ppsc_pkg::cmd_t      cmd,
    input  logic                in_valid,
    output logic                in_ready
);

    import ppsc_pkg::*;

    typedef enum logic [3:0] {
        CLEAR,
        SIEVE_RD,
        SIEVE_CHK,
        MARK,
        IDLE,
        PAIR_INIT,
        SCAN,
        SQUARE,
        ACCUM,
        NEXT,
        DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    cmd.sieve_init = 1'b1;
                    state_next     = SIEVE_RD;
                end
            end
            SIEVE_RD:
            begin
                if (status.sieve_more)
                begin
                    cmd.sieve_rd = 1'b1;
                    state_next   = SIEVE_CHK;
                end
                else
                begin
                    state_next = IDLE;
                end
            end
            SIEVE_CHK:
            begin
                if (status.map_prime)
                begin
                    cmd.mark_init = 1'b1;
                    state_next    = MARK;
                end
                else
                begin
                    cmd.sieve_next = 1'b1;
                    state_next     = SIEVE_RD;
                end
            end
            MARK:
            begin
                cmd.mark_step = 1'b1;
                if (status.mark_last)
                begin
                    cmd.sieve_next = 1'b1;
                    state_next     = SIEVE_RD;
                end
            end
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = PAIR_INIT;
                end
            end
            PAIR_INIT:
            begin
                if (status.skip_m)
                begin
                    state_next = NEXT;
                end
                else
                begin
                    cmd.pair_init = 1'b1;
                    state_next    = SCAN;
                end
            end
            SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = SQUARE;
                end
            end
            SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ACCUM;
            end
            ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = NEXT;
            end
            NEXT:
            begin
                if (status.last_m)
                begin
                    state_next = DONE;
                end
                else
                begin
                    cmd.win_next = 1'b1;
                    state_next   = PAIR_INIT;
                end
            end
            DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
            begin
                state_next = CLEAR;
            end
        endcase
    end

endmodule

/* design/prime_pair_sum_counter.sv */
// prime_pair_sum_counter: top level, joins the controller and the datapath
// depends on ppsc_pkg, ppsc_ctrl, ppsc_datapath (and through it ppsc_ram)
//
// usage:
// after reset the composite map is cleared, one entry a cycle, and then
// sieved from the map's single write port; in_ready stays low until the
// sieve is done
// each request on the n channel (valid/ready) gives one result on the out
// channel: pair_count, window_sum, window_sum_sq and window_count
// a request scans n itself, then each window number M inside [4, LIMIT-1];
// window numbers outside that range are skipped without a scan; the pair
// scan does one map lookup pair per cycle through the two read ports of the
// map memory; one request is worked at a time
// the finished result sits in an output register, so the next request is
// taken while it waits; a stalled receiver holds only that register and
// stops the block once the next result is ready
// cfg (valid/ready, always ready) writes window_half, reset value 100,
// clamped to 1024; write it only while no request is in flight
`timescale 1ns / 1ps

module prime_pair_sum_counter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ppsc_pkg::WIN_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ppsc_pkg::NW-1:0]      n,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ppsc_pkg::PC_W-1:0]    pair_count,
    output logic [ppsc_pkg::SUM_W-1:0]   window_sum,
    output logic [ppsc_pkg::SQ_W-1:0]    window_sum_sq,
    output logic [ppsc_pkg::CNT_W-1:0]   window_count
);

    import ppsc_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    ppsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .cmd      (cmd),
        .in_valid (in_valid),
        .in_ready (in_ready)
    );

    ppsc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .n             (n),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pair_count    (pair_count),
        .window_sum    (window_sum),
        .window_sum_sq (window_sum_sq),
        .window_count  (window_count)
    );

endmodule
